FILE: design/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, widths and codes of the Bezier path speed evaluator.
// ----------------------------------------------------------------------------
package bse_pkg;

	// number of control points per axis
	localparam int NUM_POINTS = 8;
	// number of derivative points, also the degree factor
	localparam int NumD = NUM_POINTS - 1;
	localparam int PtAw = $clog2(NUM_POINTS);
	// derivative point width: 33-bit difference times the degree
	localparam int DW = 33 + $clog2(NUM_POINTS);
	// shared multiplier operand and product widths
	localparam int MaW = DW + 1;
	localparam int MbW = 33;
	localparam int PW = MaW + MbW;
	// de Casteljau blend sum width
	localparam int CW = MaW + 18;
	// normalising shift count width
	localparam int SW = $clog2(DW - 30 + 1);
	// magnitude width after shifting back, and dividend width
	localparam int VW = DW + 1;
	localparam int DivW = VW + 32;

	// function codes
	localparam logic [1:0] FuncLoad  = 2'd0;
	localparam logic [1:0] FuncSpeed = 2'd1;
	localparam logic [1:0] FuncStart = 2'd2;
	localparam logic [1:0] FuncRsvd  = 2'd3;

	localparam logic [16:0] GammaOne = 17'd65536;
	localparam logic [31:0] TfReset  = 32'd65536;

	typedef logic [PtAw-1:0] pt_addr_t;
	typedef logic [$clog2(NUM_POINTS)-1:0] len_t;
	typedef logic signed [DW-1:0] dval_t;

	typedef struct packed {
		logic [1:0]         func;
		logic               axis;
		logic [2:0]         point_index;
		logic signed [31:0] point_value;
		logic [16:0]        gamma;
		logic [31:0]        tan_norm;
	} bse_in_t;

	typedef struct packed {
		logic [31:0] speed;
		logic        saturated;
	} bse_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CAST,
		ST_NORM,
		ST_SQA,
		ST_SQB,
		ST_ROOT,
		ST_MLO,
		ST_MHI,
		ST_CHK,
		ST_DIV,
		ST_FIN
	} bse_state_t;

endpackage

FILE: design/bse_in_if.sv
// ----------------------------------------------------------------------------
// bse_in_if
// Request channel: valid/ready handshake carrying one input beat.
// ----------------------------------------------------------------------------
interface bse_in_if;
	logic             valid;
	logic             ready;
	bse_pkg::bse_in_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: design/bse_out_if.sv
// ----------------------------------------------------------------------------
// bse_out_if
// Response channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface bse_out_if;
	logic              valid;
	logic              ready;
	bse_pkg::bse_out_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: design/bse_ram.sv
// ----------------------------------------------------------------------------
// bse_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bse_ram #(
	parameter int Width = 32,
	parameter int Depth = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/bezier_speed_evaluator.sv
// ----------------------------------------------------------------------------
// bezier_speed_evaluator
// Desired speed along a planar Bezier path: derivative points evaluated by
// de Casteljau, norm by iterative root, scaled and divided bit-serially.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  req     | in  | func, axis, point_index, point_value, gamma, tan_norm
//  rsp     | out | speed, saturated
//  cfg     | in  | tf_reciprocal (cfg_we, cfg_wdata)
//
// A load beat is written as it is taken and leaves req ready. A query runs a
// read pass, de Casteljau per axis through the shared multiplier, a
// normalising shift, the squares, the iterative root, the scaling and the
// divide, with the root and divider giving one bit a cycle; a saturated
// query skips the divide. req is not ready during a query; rsp sits in an
// output register, so a new query is taken while a result waits. Reset leaves
// the point stores undefined and tf_reciprocal at one.
module bezier_speed_evaluator (
	input  logic        clk,
	input  logic        arst_n,
	bse_in_if.sink      req,
	bse_out_if.source   rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	bse_pkg::bse_state_t state_q, state_d;

	logic [31:0]          tf_q;
	logic [16:0]          g_q;
	logic [31:0]          tn_q;
	logic [5:0]           cnt_q;
	logic signed [31:0]   xprev_q, yprev_q;
	bse_pkg::dval_t       wx_q [bse_pkg::NumD];
	bse_pkg::dval_t       wy_q [bse_pkg::NumD];
	bse_pkg::len_t        len_q, j_q;
	logic                 ax_q;
	logic [bse_pkg::DW-1:0] a_q, b_q;
	logic [bse_pkg::SW-1:0] s_q;
	logic [63:0]          n_q, res_q, bit_q;
	logic [bse_pkg::DivW-1:0] p_q;
	logic [31:0]          rem_q, q_q;
	logic                 sat_q;
	logic                 out_valid_q;
	bse_pkg::bse_out_t    out_q;

	logic                 acc, ld_we_x, ld_we_y, slot_free, fin_go;
	logic                 norm_big;
	logic [31:0]          xr_data, yr_data;
	bse_pkg::pt_addr_t    r_addr, w_addr;
	logic signed [bse_pkg::MaW-1:0] mul_a;
	logic signed [bse_pkg::MbW-1:0] mul_b;
	logic signed [bse_pkg::PW-1:0]  mul_p;
	bse_pkg::dval_t       cw0, cw1, cst_new;
	logic signed [bse_pkg::CW-1:0] cst_sum;
	logic [bse_pkg::CW-1:0] cst_mag, cst_rnd, cst_res;
	logic [63:0]          rt_try;
	logic [32:0]          dv_try;
	logic [bse_pkg::VW-1:0] v_w;
	logic signed [32:0]   dx_diff, dy_diff;
	bse_pkg::dval_t       dx_new, dy_new;

	// handshake qualifiers
	assign acc       = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign w_addr    = bse_pkg::pt_addr_t'(req.data.point_index);
	assign ld_we_x   = acc && (req.data.func == bse_pkg::FuncLoad) && !req.data.axis
		&& (32'(req.data.point_index) < bse_pkg::NUM_POINTS);
	assign ld_we_y   = acc && (req.data.func == bse_pkg::FuncLoad) && req.data.axis
		&& (32'(req.data.point_index) < bse_pkg::NUM_POINTS);
	assign r_addr    = bse_pkg::pt_addr_t'(cnt_q);

	bse_ram #(.Width(32), .Depth(bse_pkg::NUM_POINTS)) u_xram (
		.clk(clk), .we(ld_we_x), .waddr(w_addr), .wdata(req.data.point_value),
		.raddr(r_addr), .rdata(xr_data)
	);

	bse_ram #(.Width(32), .Depth(bse_pkg::NUM_POINTS)) u_yram (
		.clk(clk), .we(ld_we_y), .waddr(w_addr), .wdata(req.data.point_value),
		.raddr(r_addr), .rdata(yr_data)
	);

	// derivative points from consecutive reads
	assign dx_diff = 33'(signed'(xr_data)) - 33'(xprev_q);
	assign dy_diff = 33'(signed'(yr_data)) - 33'(yprev_q);
	assign dx_new  = bse_pkg::dval_t'(dx_diff) * bse_pkg::dval_t'(bse_pkg::NumD);
	assign dy_new  = bse_pkg::dval_t'(dy_diff) * bse_pkg::dval_t'(bse_pkg::NumD);

	// blend operands always sit in the two lowest slots
	assign cw0 = ax_q ? wy_q[0] : wx_q[0];
	assign cw1 = ax_q ? wy_q[1] : wx_q[1];

	// steer the shared multiplier
	assign v_w = bse_pkg::VW'(res_q[31:0]) << s_q;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			bse_pkg::ST_CAST: begin
				mul_a = bse_pkg::MaW'(cw1) - bse_pkg::MaW'(cw0);
				mul_b = bse_pkg::MbW'(g_q);
			end
			bse_pkg::ST_SQA: begin
				mul_a = bse_pkg::MaW'(a_q[30:0]);
				mul_b = bse_pkg::MbW'(a_q[30:0]);
			end
			bse_pkg::ST_SQB: begin
				mul_a = bse_pkg::MaW'(b_q[30:0]);
				mul_b = bse_pkg::MbW'(b_q[30:0]);
			end
			bse_pkg::ST_MLO: begin
				mul_a = bse_pkg::MaW'(v_w[31:0]);
				mul_b = bse_pkg::MbW'(tf_q);
			end
			bse_pkg::ST_MHI: begin
				mul_a = bse_pkg::MaW'(v_w[bse_pkg::VW-1:32]);
				mul_b = bse_pkg::MbW'(tf_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// blend a + g*(b-a), rounded half away from zero
	assign cst_sum = (bse_pkg::CW'(cw0) <<< 16) + bse_pkg::CW'(mul_p);
	assign cst_mag = cst_sum[bse_pkg::CW-1] ? -cst_sum : cst_sum;
	assign cst_rnd = (cst_mag + bse_pkg::CW'(32768)) >> 16;
	assign cst_res = cst_sum[bse_pkg::CW-1] ? -cst_rnd : cst_rnd;
	assign cst_new = bse_pkg::dval_t'(cst_res);

	assign norm_big = |((a_q | b_q) >> 31);
	assign rt_try   = res_q + bit_q;
	assign dv_try   = {rem_q, q_q[31]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bse_pkg::ST_IDLE: begin
				if (acc && (req.data.func == bse_pkg::FuncSpeed
					|| req.data.func == bse_pkg::FuncStart)) begin
					state_d = bse_pkg::ST_LOAD;
				end
			end
			bse_pkg::ST_LOAD: begin
				if (32'(cnt_q) == bse_pkg::NUM_POINTS) state_d = bse_pkg::ST_CAST;
			end
			bse_pkg::ST_CAST: begin
				if (len_q < 2 && ax_q) state_d = bse_pkg::ST_NORM;
			end
			bse_pkg::ST_NORM: begin
				if (!norm_big) state_d = bse_pkg::ST_SQA;
			end
			bse_pkg::ST_SQA: state_d = bse_pkg::ST_SQB;
			bse_pkg::ST_SQB: state_d = bse_pkg::ST_ROOT;
			bse_pkg::ST_ROOT: begin
				if (bit_q[0]) state_d = bse_pkg::ST_MLO;
			end
			bse_pkg::ST_MLO: state_d = bse_pkg::ST_MHI;
			bse_pkg::ST_MHI: state_d = bse_pkg::ST_CHK;
			bse_pkg::ST_CHK: begin
				if (tn_q == '0 || p_q[bse_pkg::DivW-1:32] >= bse_pkg::VW'(tn_q)) begin
					state_d = bse_pkg::ST_FIN;
				end else begin
					state_d = bse_pkg::ST_DIV;
				end
			end
			bse_pkg::ST_DIV: begin
				if (cnt_q == 6'd31) state_d = bse_pkg::ST_FIN;
			end
			bse_pkg::ST_FIN: begin
				if (slot_free) state_d = bse_pkg::ST_IDLE;
			end
			default: state_d = bse_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		req.ready = (state_q == bse_pkg::ST_IDLE);
		fin_go    = (state_q == bse_pkg::ST_FIN) && slot_free;
		rsp.valid = out_valid_q;
		rsp.data  = out_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bse_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			tf_q        <= bse_pkg::TfReset;
		end else begin
			state_q <= state_d;
			if (cfg_we) tf_q <= cfg_wdata;
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers, advanced per state
	always_ff @(posedge clk) begin
		unique case (state_q)
			bse_pkg::ST_IDLE: begin
				cnt_q <= '0;
				if (req.data.func == bse_pkg::FuncStart) begin
					g_q <= '0;
				end else if (req.data.gamma > bse_pkg::GammaOne) begin
					g_q <= bse_pkg::GammaOne;
				end else begin
					g_q <= req.data.gamma;
				end
				tn_q <= req.data.tan_norm;
			end
			bse_pkg::ST_LOAD: begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q != '0) begin
					xprev_q <= signed'(xr_data);
					yprev_q <= signed'(yr_data);
				end
				if (cnt_q >= 6'd2) begin
					for (int k = 0; k < bse_pkg::NumD - 1; k++) begin
						wx_q[k] <= wx_q[k + 1];
						wy_q[k] <= wy_q[k + 1];
					end
					wx_q[bse_pkg::NumD - 1] <= dx_new;
					wy_q[bse_pkg::NumD - 1] <= dy_new;
				end
				len_q <= bse_pkg::len_t'(bse_pkg::NumD);
				j_q   <= '0;
				ax_q  <= 1'b0;
				s_q   <= '0;
			end
			bse_pkg::ST_CAST: begin
				if (len_q < 2) begin
					// axis finished: start the other or take magnitudes
					ax_q  <= 1'b1;
					len_q <= bse_pkg::len_t'(bse_pkg::NumD);
					a_q   <= wx_q[0][bse_pkg::DW-1] ? -wx_q[0] : wx_q[0];
					b_q   <= wy_q[0][bse_pkg::DW-1] ? -wy_q[0] : wy_q[0];
				end else begin
					// rotate the row, blending while inside the round
					for (int k = 0; k < bse_pkg::NumD - 1; k++) begin
						if (ax_q) wy_q[k] <= wy_q[k + 1];
						else      wx_q[k] <= wx_q[k + 1];
					end
					if (ax_q) begin
						wy_q[bse_pkg::NumD - 1] <= (j_q < len_q - 1'b1) ? cst_new : cw0;
					end else begin
						wx_q[bse_pkg::NumD - 1] <= (j_q < len_q - 1'b1) ? cst_new : cw0;
					end
					if (32'(j_q) == bse_pkg::NumD - 1) begin
						j_q   <= '0;
						len_q <= len_q - 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
			end
			bse_pkg::ST_NORM: begin
				if (norm_big) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					s_q <= s_q + 1'b1;
				end
			end
			bse_pkg::ST_SQA: n_q <= 64'(mul_p);
			bse_pkg::ST_SQB: begin
				n_q   <= n_q + 64'(mul_p);
				res_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			bse_pkg::ST_ROOT: begin
				if (n_q >= rt_try) begin
					n_q   <= n_q - rt_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			bse_pkg::ST_MLO: p_q <= bse_pkg::DivW'(mul_p);
			bse_pkg::ST_MHI: p_q <= p_q + (bse_pkg::DivW'(mul_p) << 32);
			bse_pkg::ST_CHK: begin
				sat_q <= (tn_q == '0) || (p_q[bse_pkg::DivW-1:32] >= bse_pkg::VW'(tn_q));
				rem_q <= p_q[63:32];
				q_q   <= p_q[31:0];
				cnt_q <= '0;
			end
			bse_pkg::ST_DIV: begin
				// one quotient bit per cycle
				cnt_q <= cnt_q + 6'd1;
				if (dv_try >= {1'b0, tn_q}) begin
					rem_q <= 32'(dv_try - {1'b0, tn_q});
					q_q   <= {q_q[30:0], 1'b1};
				end else begin
					rem_q <= dv_try[31:0];
					q_q   <= {q_q[30:0], 1'b0};
				end
			end
			bse_pkg::ST_FIN: begin
				if (slot_free) begin
					out_q.speed     <= sat_q ? 32'hFFFF_FFFF : q_q;
					out_q.saturated <= sat_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

endmodule

FILE: design/bse_checker.sv
// ----------------------------------------------------------------------------
// bse_checker
// Port-level checks of the speed evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_func,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_speed,
	input logic        rsp_sat
);

	// hold a stalled result beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	// drop ready once a query is taken
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready
		&& (req_func == bse_pkg::FuncSpeed || req_func == bse_pkg::FuncStart)
		|=> !req_ready)
		else $error("ready stayed high after a query");

	// a load completes in its own cycle
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == bse_pkg::FuncLoad |=> req_ready)
		else $error("load beat stalled the request channel");

	// saturation always shows all ones
	a_sat_speed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_sat |-> rsp_speed == 32'hFFFF_FFFF)
		else $error("saturated result without full-scale speed");

endmodule

bind bezier_speed_evaluator bse_checker u_bse_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_func(req.data.func),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_speed(rsp.data.speed),
	.rsp_sat(rsp.data.saturated)
);

FILE: dv/tb_bezier_speed_evaluator.sv
// ----------------------------------------------------------------------------
// tb_bezier_speed_evaluator
// Self-checking bench for the Bezier path speed evaluator. A short directed
// table loads the control points and hits the extreme and saturating cases,
// then random loads and queries run under three handshake idling patterns
// with several final-time reciprocal settings. Every result beat is compared
// with the table's expected value or a local fixed-point predictor of the speed.
// ----------------------------------------------------------------------------
module tb_bezier_speed_evaluator;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [31:0] coord_arr_t [bse_pkg::NUM_POINTS];

	typedef struct {
		bse_pkg::bse_in_t  beat;
		bit                typed;
		bse_pkg::bse_out_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	bse_in_if  req();
	bse_out_if rsp();

	bezier_speed_evaluator dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	coord_arr_t  x_pts, y_pts;
	logic [31:0] tf_recip = bse_pkg::TfReset;

	bse_pkg::bse_out_t speed_q[$];
	dir_row_t dir_rows[$];
	int       src_idle_pct = 0;
	int       snk_idle_pct = 0;
	int       fail_cnt = 0;
	int       queries_sent = 0;
	int       loads_sent = 0;
	int       results_seen = 0;
	int       quiet_cycles = 0;

	always #5 clk = ~clk;

	// fixed-point speed predictor
	function automatic longint round_q16(longint v);
		if (v >= 0) begin
			return (v + 32768) >>> 16;
		end
		return -((-v + 32768) >>> 16);
	endfunction

	function automatic longint casteljau_deriv(coord_arr_t p, longint g);
		longint d [bse_pkg::NumD];
		for (int i = 0; i < bse_pkg::NumD; i++) begin
			d[i] = longint'(bse_pkg::NumD) * (longint'(p[i+1]) - longint'(p[i]));
		end
		for (int r = 1; r < bse_pkg::NumD; r++) begin
			for (int i = 0; i < bse_pkg::NumD - r; i++) begin
				d[i] = round_q16((65536 - g) * d[i] + g * d[i+1]);
			end
		end
		return d[0];
	endfunction

	function automatic longint unsigned floor_root(longint unsigned n);
		longint unsigned res = 0;
		longint unsigned bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic bse_pkg::bse_out_t path_speed(bse_pkg::bse_in_t b);
		longint            g, dx, dy;
		longint unsigned   a, c, v;
		int                s = 0;
		logic [127:0]      quo;
		bse_pkg::bse_out_t o;
		if (b.func == bse_pkg::FuncStart) g = 0;
		else g = (b.gamma > bse_pkg::GammaOne) ? 65536 : longint'(b.gamma);
		dx = casteljau_deriv(x_pts, g);
		dy = casteljau_deriv(y_pts, g);
		a = (dx < 0) ? -dx : dx;
		c = (dy < 0) ? -dy : dy;
		while ((a | c) >= (64'd1 << 31)) begin
			a >>= 1;
			c >>= 1;
			s++;
		end
		v = floor_root(a * a + c * c) << s;
		o.speed = '1;
		o.saturated = 1'b1;
		if (b.tan_norm != 0) begin
			quo = (128'(v) * 128'(tf_recip)) / 128'(b.tan_norm);
			if (quo[127:32] == 0) begin
				o.speed = quo[31:0];
				o.saturated = 1'b0;
			end
		end
		return o;
	endfunction

	// drive one request beat, hold until accepted, then update the predictor
	task automatic send_beat(bse_pkg::bse_in_t b, bit typed, bse_pkg::bse_out_t want);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= b;
		do @(posedge clk); while (!req.ready);
		case (b.func)
			bse_pkg::FuncLoad: begin
				loads_sent++;
				if (b.axis) y_pts[b.point_index] = b.point_value;
				else x_pts[b.point_index] = b.point_value;
			end
			bse_pkg::FuncSpeed, bse_pkg::FuncStart: begin
				queries_sent++;
				speed_q.push_back(typed ? want : path_speed(b));
			end
			default: ;
		endcase
	endtask

	// wait for every result, let the block settle, then write the register
	task automatic write_tf(logic [31:0] val);
		req.valid <= 1'b0;
		while (speed_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tf_recip = val;
	endtask

	function automatic bse_pkg::bse_in_t rand_beat();
		bse_pkg::bse_in_t b;
		int               r = $urandom_range(0, 99);
		b.func = (r < 40) ? bse_pkg::FuncLoad : (r < 92) ? bse_pkg::FuncSpeed
			: (r < 97) ? bse_pkg::FuncStart : bse_pkg::FuncRsvd;
		b.axis = 1'($urandom_range(0, 1));
		b.point_index = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 7) == 0) b.point_value = $urandom;
		else b.point_value = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		if ($urandom_range(0, 9) == 0) b.gamma = 17'($urandom_range(0, 131071));
		else b.gamma = 17'($urandom_range(0, 65536));
		r = $urandom_range(0, 19);
		if (r == 0) b.tan_norm = '0;
		else if (r < 6) b.tan_norm = $urandom;
		else b.tan_norm = $urandom_range(1 << 12, 1 << 20);
		return b;
	endfunction

	function automatic dir_row_t mk(logic [1:0] f, logic ax, logic [2:0] idx,
			logic [31:0] val, logic [16:0] gam, logic [31:0] tn,
			bit typed = 0, logic [31:0] spd = 0, logic sat = 0);
		dir_row_t d;
		d.beat = '{f, ax, idx, val, gam, tn};
		d.typed = typed;
		d.want = '{spd, sat};
		return d;
	endfunction

	// check result beats and drive the receiver's ready
	always @(posedge clk) begin
		if (rsp.valid && rsp.ready) begin
			results_seen++;
			if (speed_q.size() == 0) begin
				$display("%0t: unexpected result speed=%h sat=%b", $time,
					rsp.data.speed, rsp.data.saturated);
				fail_cnt++;
			end else begin
				bse_pkg::bse_out_t w;
				w = speed_q.pop_front();
				if (w.speed !== rsp.data.speed) begin
					$display("%0t: speed expected %h actual %h", $time, w.speed,
						rsp.data.speed);
					fail_cnt++;
				end
				if (w.saturated !== rsp.data.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time,
						w.saturated, rsp.data.saturated);
					fail_cnt++;
				end
			end
		end
		rsp.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	// watchdog on cycles with no beat in either direction
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		bse_pkg::bse_out_t none;
		logic [31:0]       tf_set [6];
		none = '0;
		tf_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd65536, 32'd0, 32'd0};
		tf_set[4] = $urandom;
		tf_set[5] = $urandom_range(1 << 14, 1 << 18);
		req.valid = 1'b0;
		req.data  = '0;
		rsp.ready = 1'b0;

		// flat path first: all points equal, so the derivative is zero
		for (int i = 0; i < bse_pkg::NUM_POINTS; i++) begin
			dir_rows.push_back(mk(bse_pkg::FuncLoad, 1'b0, 3'(i), 32'h0003_0000, 0, 0));
			dir_rows.push_back(mk(bse_pkg::FuncLoad, 1'b1, 3'(i), 32'hFFFD_0000, 0, 0));
		end
		dir_rows.push_back(mk(bse_pkg::FuncSpeed, 0, 0, 0, 17'd30000, 32'd1,
			1, 32'd0, 1'b0));
		dir_rows.push_back(mk(bse_pkg::FuncSpeed, 0, 0, 0, 17'd30000, 32'd0,
			1, '1, 1'b1));
		dir_rows.push_back(mk(bse_pkg::FuncRsvd, 1, 7, '1, '1, '1));
		// extreme coordinates, then overflow and gamma clamping
		dir_rows.push_back(mk(bse_pkg::FuncLoad, 1'b0, 0, 32'h8000_0000, 0, 0));
		dir_rows.push_back(mk(bse_pkg::FuncLoad, 1'b0, 7, 32'h7FFF_FFFF, 0, 0));
		dir_rows.push_back(mk(bse_pkg::FuncLoad, 1'b1, 3, 32'h7FFF_FFFF, 0, 0));
		dir_rows.push_back(mk(bse_pkg::FuncSpeed, 0, 0, 0, 17'd0, 32'd1, 1, '1, 1'b1));
		dir_rows.push_back(mk(bse_pkg::FuncStart, 0, 0, 0, 17'h1FFFF, 32'hFFFF_FFFF));
		dir_rows.push_back(mk(bse_pkg::FuncSpeed, 0, 0, 0, 17'h1FFFF, 32'h0001_0000));
		dir_rows.push_back(mk(bse_pkg::FuncSpeed, 0, 0, 0, bse_pkg::GammaOne,
			32'hFFFF_FFFF));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 38;
		snk_idle_pct = 71;
		foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

		// random part: six register settings over three idling patterns
		for (int ph = 0; ph < 6; ph++) begin
			write_tf(tf_set[ph]);
			src_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 71 : 0;
			snk_idle_pct = (ph < 2) ? 71 : (ph < 4) ? 38 : 0;
			repeat (175) send_beat(rand_beat(), 0, none);
		end
		req.valid <= 1'b0;

		while (speed_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Covered %0d loads and %0d speed queries, %0d results checked,",
			loads_sent, queries_sent, results_seen);
		$display("across six final-time settings and three idling patterns.");
		if (fail_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: files.f
design/bse_pkg.sv
design/bse_in_if.sv
design/bse_out_if.sv
design/bse_ram.sv
design/bezier_speed_evaluator.sv
design/bse_checker.sv
dv/tb_bezier_speed_evaluator.sv
